### sv/tqcs_pkg.sv
package tqcs_pkg;

    localparam int NUM_TAXELS = 128;
    localparam int TAXEL_AW   = (NUM_TAXELS > 1) ? $clog2(NUM_TAXELS) : 1;

    localparam int TAXEL_W  = 7;
    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 64;
    localparam int SMOOTH_W = 48;
    localparam int CURVE_W  = 32;

    localparam logic signed [COEF_W-1:0] ONE_Q32 = 64'sh0000_0001_0000_0000;

    // alpha = 9830/65536, keep = 1 - alpha
    localparam logic [13:0] ALPHA_Q16 = 14'd9830;
    localparam logic [15:0] KEEP_Q16  = 16'd55706;

    // output queue; credits bound everything in flight to its depth
    localparam int OUT_DEPTH = 8;
    localparam int OUT_AW    = 3;
    localparam int CREDIT_W  = 4;

    localparam int CFG_AW = 5;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_CAL    = 1'b1;

    typedef enum logic [2:0] {
        REG_FIRST_REF,
        REG_SECOND_REF,
        REG_THIRD_REF,
        REG_NOISE_FLOOR,
        REG_OUTPUT_CEIL
    } t_reg_idx;

    typedef struct packed {
        logic signed [COEF_W-1:0] square;
        logic signed [COEF_W-1:0] linear;
        logic signed [COEF_W-1:0] offset;
    } t_coef;

    typedef struct packed {
        logic [TAXEL_W-1:0]  taxel;
        logic [SAMPLE_W-1:0] pressure;
    } t_result;

endpackage

### sv/tqcs_if.sv
interface tqcs_in_if;
    logic                           valid;
    logic                           ready;
    logic                           kind;
    logic [tqcs_pkg::TAXEL_W-1:0]   taxel;
    logic [tqcs_pkg::SAMPLE_W-1:0]  reading;
    logic [tqcs_pkg::SAMPLE_W-1:0]  second_reading;
    logic [tqcs_pkg::SAMPLE_W-1:0]  third_reading;

    modport source (output valid, kind, taxel, reading, second_reading, third_reading,
                    input ready);
    modport sink (input valid, kind, taxel, reading, second_reading, third_reading,
                  output ready);
endinterface

interface tqcs_out_if;
    logic                           valid;
    logic                           ready;
    logic [tqcs_pkg::TAXEL_W-1:0]   out_taxel;
    logic [tqcs_pkg::SAMPLE_W-1:0]  pressure;

    modport source (output valid, out_taxel, pressure, input ready);
    modport sink (input valid, out_taxel, pressure, output ready);
endinterface

### sv/tqcs_ram.sv
module tqcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

### sv/tqcs_fit.sv
module tqcs_fit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [15:0]           i_x0,
    input  logic [15:0]           i_x1,
    input  logic [15:0]           i_x2,
    input  logic [15:0]           i_y0,
    input  logic [15:0]           i_y1,
    input  logic [15:0]           i_y2,
    output logic                  o_done,
    output tqcs_pkg::t_coef       o_coef
);

    localparam int OPA_W = 18;
    localparam int OPB_W = 51;
    localparam int PROD_W = OPA_W + OPB_W;
    localparam int ACC_W = 70;
    localparam int DIV_W = ACC_W + 32;
    localparam int CNT_W = $clog2(DIV_W);
    localparam int COEF_W_L = tqcs_pkg::COEF_W;

    typedef enum logic [4:0] {
        ST_IDLE, ST_T0, ST_DET, ST_Q12, ST_Q02, ST_Q01,
        ST_M12, ST_R12, ST_M02, ST_R02, ST_M01, ST_R01,
        ST_NA0, ST_NA1, ST_NA2, ST_NB0, ST_NB1, ST_NB2,
        ST_NC0, ST_NC1, ST_NC2, ST_DIV_LD, ST_DIV
    } t_state;

    typedef enum logic [1:0] {SEL_SQUARE, SEL_LINEAR, SEL_OFFSET} t_sel;

    t_state r_state;
    t_sel   r_sel;

    logic [15:0] r_x0, r_x1, r_x2, r_y0, r_y1, r_y2;
    logic signed [OPB_W-1:0] r_t0, r_det, r_q12, r_q02, r_q01, r_m, r_r12, r_r02, r_r01;
    logic signed [ACC_W-1:0] r_acc;

    logic [DIV_W-1:0]  r_dvd;
    logic [OPB_W:0]    r_rem;
    logic [OPB_W-1:0]  r_dmag;
    logic              r_neg;
    logic [CNT_W-1:0]  r_cnt;

    logic signed [OPA_W-1:0]  x0, x1, x2, y0, y1, y2, d01, d02, d12, s01, s02, s12;
    logic signed [OPA_W-1:0]  ma;
    logic signed [OPB_W-1:0]  mb;
    logic signed [PROD_W-1:0] prod;
    logic signed [ACC_W-1:0]  prod_x;

    logic signed [ACC_W-1:0]  n_num;
    logic [ACC_W-1:0]         n_mag;
    logic [OPB_W:0]           n_trial;
    logic                     n_ge;
    logic [OPB_W:0]           n_rem;
    logic [DIV_W-1:0]         n_dvd;
    logic signed [COEF_W_L-1:0] n_q;

    assign x0  = $signed({2'b00, r_x0});
    assign x1  = $signed({2'b00, r_x1});
    assign x2  = $signed({2'b00, r_x2});
    assign y0  = $signed({2'b00, r_y0});
    assign y1  = $signed({2'b00, r_y1});
    assign y2  = $signed({2'b00, r_y2});
    assign d01 = x0 - x1;
    assign d02 = x0 - x2;
    assign d12 = x1 - x2;
    assign s01 = x0 + x1;
    assign s02 = x0 + x2;
    assign s12 = x1 + x2;

    always_comb begin
        ma = '0;
        mb = '0;
        case (r_state)
            ST_T0:  begin ma = d01; mb = OPB_W'(d02); end
            ST_DET: begin ma = d12; mb = r_t0; end
            ST_Q12: begin ma = d12; mb = OPB_W'(s12); end
            ST_Q02: begin ma = d02; mb = OPB_W'(s02); end
            ST_Q01: begin ma = d01; mb = OPB_W'(s01); end
            ST_M12: begin ma = x1; mb = OPB_W'(x2); end
            ST_R12: begin ma = d12; mb = r_m; end
            ST_M02: begin ma = x0; mb = OPB_W'(x2); end
            ST_R02: begin ma = d02; mb = r_m; end
            ST_M01: begin ma = x0; mb = OPB_W'(x1); end
            ST_R01: begin ma = d01; mb = r_m; end
            ST_NA0: begin ma = y0; mb = OPB_W'(d12); end
            ST_NA1: begin ma = y1; mb = OPB_W'(d02); end
            ST_NA2: begin ma = y2; mb = OPB_W'(d01); end
            ST_NB0: begin ma = y0; mb = r_q12; end
            ST_NB1: begin ma = y1; mb = r_q02; end
            ST_NB2: begin ma = y2; mb = r_q01; end
            ST_NC0: begin ma = y0; mb = r_r12; end
            ST_NC1: begin ma = y1; mb = r_r02; end
            ST_NC2: begin ma = y2; mb = r_r01; end
            default: begin ma = '0; mb = '0; end
        endcase
    end

    assign prod   = ma * mb;
    assign prod_x = ACC_W'(prod);

    // the linear numerator carries an extra negation
    assign n_num = (r_sel == SEL_LINEAR) ? -r_acc : r_acc;
    assign n_mag = n_num[ACC_W-1] ? ACC_W'(-n_num) : ACC_W'(n_num);

    // restoring division, one quotient bit per cycle
    assign n_trial = {r_rem[OPB_W-1:0], r_dvd[DIV_W-1]};
    assign n_ge    = n_trial >= {1'b0, r_dmag};
    assign n_rem   = n_ge ? n_trial - {1'b0, r_dmag} : n_trial;
    assign n_dvd   = {r_dvd[DIV_W-2:0], n_ge};

    always_comb begin
        if (r_neg) begin
            if (|n_dvd[DIV_W-1:COEF_W_L-1]) begin
                n_q = {1'b1, {(COEF_W_L-1){1'b0}}};
            end else begin
                n_q = -$signed(n_dvd[COEF_W_L-1:0]);
            end
        end else begin
            if (|n_dvd[DIV_W-1:COEF_W_L-1]) begin
                n_q = {1'b0, {(COEF_W_L-1){1'b1}}};
            end else begin
                n_q = $signed(n_dvd[COEF_W_L-1:0]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_sel   <= SEL_SQUARE;
            o_done  <= 1'b0;
        end else begin
            o_done <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (i_start) begin
                        r_x0 <= i_x0;
                        r_x1 <= i_x1;
                        r_x2 <= i_x2;
                        r_y0 <= i_y0;
                        r_y1 <= i_y1;
                        r_y2 <= i_y2;
                        r_state <= ST_T0;
                    end
                end
                ST_T0:  begin r_t0 <= prod[OPB_W-1:0]; r_state <= ST_DET; end
                ST_DET: begin r_det <= prod[OPB_W-1:0]; r_state <= ST_Q12; end
                ST_Q12: begin
                    if (r_det == '0) begin
                        // coinciding readings: identity curve
                        o_coef.square <= '0;
                        o_coef.linear <= tqcs_pkg::ONE_Q32;
                        o_coef.offset <= '0;
                        o_done  <= 1'b1;
                        r_state <= ST_IDLE;
                    end else begin
                        r_q12   <= prod[OPB_W-1:0];
                        r_state <= ST_Q02;
                    end
                end
                ST_Q02: begin r_q02 <= prod[OPB_W-1:0]; r_state <= ST_Q01; end
                ST_Q01: begin r_q01 <= prod[OPB_W-1:0]; r_state <= ST_M12; end
                ST_M12: begin r_m <= prod[OPB_W-1:0]; r_state <= ST_R12; end
                ST_R12: begin r_r12 <= prod[OPB_W-1:0]; r_state <= ST_M02; end
                ST_M02: begin r_m <= prod[OPB_W-1:0]; r_state <= ST_R02; end
                ST_R02: begin r_r02 <= prod[OPB_W-1:0]; r_state <= ST_M01; end
                ST_M01: begin r_m <= prod[OPB_W-1:0]; r_state <= ST_R01; end
                ST_R01: begin r_r01 <= prod[OPB_W-1:0]; r_state <= ST_NA0; end
                ST_NA0: begin r_acc <= prod_x; r_state <= ST_NA1; end
                ST_NA1: begin r_acc <= r_acc - prod_x; r_state <= ST_NA2; end
                ST_NA2: begin
                    r_acc   <= r_acc + prod_x;
                    r_sel   <= SEL_SQUARE;
                    r_state <= ST_DIV_LD;
                end
                ST_NB0: begin r_acc <= prod_x; r_state <= ST_NB1; end
                ST_NB1: begin r_acc <= r_acc - prod_x; r_state <= ST_NB2; end
                ST_NB2: begin
                    r_acc   <= r_acc + prod_x;
                    r_sel   <= SEL_LINEAR;
                    r_state <= ST_DIV_LD;
                end
                ST_NC0: begin r_acc <= prod_x; r_state <= ST_NC1; end
                ST_NC1: begin r_acc <= r_acc - prod_x; r_state <= ST_NC2; end
                ST_NC2: begin
                    r_acc   <= r_acc + prod_x;
                    r_sel   <= SEL_OFFSET;
                    r_state <= ST_DIV_LD;
                end
                ST_DIV_LD: begin
                    r_dvd   <= {n_mag, 32'h0};
                    r_rem   <= '0;
                    r_dmag  <= r_det[OPB_W-1] ? OPB_W'(-r_det) : OPB_W'(r_det);
                    r_neg   <= n_num[ACC_W-1] ^ r_det[OPB_W-1];
                    r_cnt   <= '0;
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    r_dvd <= n_dvd;
                    r_rem <= n_rem;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(DIV_W - 1)) begin
                        case (r_sel)
                            SEL_SQUARE: begin
                                o_coef.square <= n_q;
                                r_state <= ST_NB0;
                            end
                            SEL_LINEAR: begin
                                o_coef.linear <= n_q;
                                r_state <= ST_NC0;
                            end
                            default: begin
                                o_coef.offset <= n_q;
                                o_done  <= 1'b1;
                                r_state <= ST_IDLE;
                            end
                        endcase
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

### sv/taxel_quadratic_calibrate_smooth.sv
// Per-taxel pressure conditioner. Sample words stream in at up to one per
// cycle while ready is high, with no dependence on taxel order, and each
// yields one pressure word. The pipeline reads the taxel's curve from the
// coefficient RAM on accept, evaluates it over four stages, and does the
// smoothing read-modify-write on the smoothed-value RAM with a one-entry
// bypass for back-to-back hits on the same taxel. An eight-word output queue
// with credit flow control lets input continue while results wait. A
// calibration word holds off input while its curve is fitted: up to twenty
// multiply steps on a shared 18x51 multiplier and a bit-serial division per
// coefficient. Out-of-range taxels are accepted and dropped.
module taxel_quadratic_calibrate_smooth (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    tqcs_in_if.sink                       i_in,
    tqcs_out_if.source                    o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tqcs_pkg::CFG_AW-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int AW = tqcs_pkg::TAXEL_AW;
    localparam int TW = tqcs_pkg::TAXEL_W;
    localparam int SW = tqcs_pkg::SMOOTH_W;
    localparam int CW = tqcs_pkg::CURVE_W;
    localparam int COEF_RAM_W = 3 * tqcs_pkg::COEF_W;

    // ---------------- configuration ----------------
    logic [15:0] r_ref0, r_ref1, r_ref2, r_floor, r_ceil;
    tqcs_pkg::t_reg_idx reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = tqcs_pkg::t_reg_idx'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref0  <= '0;
            r_ref1  <= '0;
            r_ref2  <= '0;
            r_floor <= '0;
            r_ceil  <= 16'hFFFF;
        end else if (psel && penable && pwrite) begin
            case (reg_idx)
                tqcs_pkg::REG_FIRST_REF:   r_ref0  <= pwdata[15:0];
                tqcs_pkg::REG_SECOND_REF:  r_ref1  <= pwdata[15:0];
                tqcs_pkg::REG_THIRD_REF:   r_ref2  <= pwdata[15:0];
                tqcs_pkg::REG_NOISE_FLOOR: r_floor <= pwdata[15:0];
                tqcs_pkg::REG_OUTPUT_CEIL: r_ceil  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            tqcs_pkg::REG_FIRST_REF:   prdata = {16'h0, r_ref0};
            tqcs_pkg::REG_SECOND_REF:  prdata = {16'h0, r_ref1};
            tqcs_pkg::REG_THIRD_REF:   prdata = {16'h0, r_ref2};
            tqcs_pkg::REG_NOISE_FLOOR: prdata = {16'h0, r_floor};
            tqcs_pkg::REG_OUTPUT_CEIL: prdata = {16'h0, r_ceil};
            default:                   prdata = '0;
        endcase
    end

    // ---------------- input ----------------
    logic                            r_busy;
    logic [tqcs_pkg::CREDIT_W-1:0]   r_credit;
    logic [AW-1:0]                   r_cal_addr;
    logic                            in_acc, in_ok, smp_acc, cal_acc, pop;
    logic [AW-1:0]                   in_addr;

    assign i_in.ready = !r_busy && (r_credit < tqcs_pkg::CREDIT_W'(tqcs_pkg::OUT_DEPTH));
    assign in_acc  = i_in.valid && i_in.ready;
    assign in_ok   = 32'(i_in.taxel) < 32'(tqcs_pkg::NUM_TAXELS);
    assign in_addr = AW'(i_in.taxel);
    assign smp_acc = in_acc && in_ok && (i_in.kind == tqcs_pkg::KIND_SAMPLE);
    assign cal_acc = in_acc && in_ok && (i_in.kind == tqcs_pkg::KIND_CAL);

    // ---------------- calibration ----------------
    logic            fit_done;
    tqcs_pkg::t_coef fit_coef;
    logic [tqcs_pkg::NUM_TAXELS-1:0] r_cvalid;

    tqcs_fit u_fit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cal_acc),
        .i_x0    (i_in.reading),
        .i_x1    (i_in.second_reading),
        .i_x2    (i_in.third_reading),
        .i_y0    (r_ref0),
        .i_y1    (r_ref1),
        .i_y2    (r_ref2),
        .o_done  (fit_done),
        .o_coef  (fit_coef)
    );

    logic [COEF_RAM_W-1:0] coef_q;

    tqcs_ram #(.WIDTH(COEF_RAM_W), .DEPTH(tqcs_pkg::NUM_TAXELS)) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (fit_done),
        .i_waddr (r_cal_addr),
        .i_wdata (fit_coef),
        .i_raddr (in_addr),
        .o_rdata (coef_q)
    );

    // ---------------- curve pipeline ----------------
    logic           r1_v, r2_v, r3_v, r4_v, r5_v, r6_v, r7_v;
    logic [TW-1:0]  r1_t, r2_t, r3_t, r4_t, r5_t, r6_t, r7_t;
    logic [15:0]    r1_x;
    logic [31:0]    r1_xsq;
    logic           r1_cv;

    logic signed [64:0]  r2_ah;
    logic [63:0]         r2_al;
    logic signed [48:0]  r2_bh;
    logic [47:0]         r2_bl;
    logic signed [63:0]  r2_c;
    logic signed [65:0]  r3_hi;
    logic signed [66:0]  r3_lo;
    logic signed [99:0]  r4_acc;
    logic signed [CW-1:0] r5_curve;
    logic signed [46:0]  r6_pc;
    logic                r6_svld, r_fwd_hit;
    logic signed [SW-1:0] r_fwd_s, r7_s;

    tqcs_pkg::t_coef     c1;
    logic signed [99:0]  acc_rnd;
    logic signed [67:0]  acc_int;
    logic signed [CW-1:0] curve_sat;

    always_comb begin
        if (r1_cv) begin
            c1 = coef_q;
        end else begin
            c1.square = '0;
            c1.linear = tqcs_pkg::ONE_Q32;
            c1.offset = '0;
        end
    end

    // truncate the Q32 fraction toward zero, then saturate to 32 bits
    assign acc_rnd = r4_acc + (r4_acc[99] ? 100'sd4294967295 : 100'sd0);
    assign acc_int = acc_rnd[99:32];
    always_comb begin
        if (acc_int[67:31] == {37{acc_int[67]}}) begin
            curve_sat = acc_int[31:0];
        end else if (acc_int[67]) begin
            curve_sat = {1'b1, {(CW-1){1'b0}}};
        end else begin
            curve_sat = {1'b0, {(CW-1){1'b1}}};
        end
    end

    // ---------------- smoothing ----------------
    logic [SW-1:0]         sv_q;
    logic signed [SW-1:0]  s_old, s_new;
    logic signed [64:0]    keep_prod;
    logic signed [65:0]    s_sum, s_rnd;
    logic [tqcs_pkg::NUM_TAXELS-1:0] r_svalid;
    logic [AW-1:0]         r5_addr, r6_addr;

    assign r5_addr = AW'(r5_t);
    assign r6_addr = AW'(r6_t);

    tqcs_ram #(.WIDTH(SW), .DEPTH(tqcs_pkg::NUM_TAXELS)) u_smooth_ram (
        .i_clk   (i_clk),
        .i_we    (r6_v),
        .i_waddr (r6_addr),
        .i_wdata (s_new),
        .i_raddr (r5_addr),
        .o_rdata (sv_q)
    );

    assign s_old = r_fwd_hit ? r_fwd_s : (r6_svld ? $signed(sv_q) : '0);
    assign keep_prod = s_old * $signed({1'b0, tqcs_pkg::KEEP_Q16});
    assign s_sum = 66'($signed({r6_pc, 16'h0})) + 66'(keep_prod);
    assign s_rnd = s_sum + (s_sum[65] ? 66'sd65535 : 66'sd0);
    assign s_new = s_rnd[63:16];

    // ---------------- output stage ----------------
    logic signed [SW-1:0] floor_q, ceil_q;
    logic [15:0]          press;

    assign floor_q = SW'($signed({1'b0, r_floor, 16'h0}));
    assign ceil_q  = SW'($signed({1'b0, r_ceil, 16'h0}));

    always_comb begin
        if (r7_s < floor_q) begin
            press = '0;
        end else if (r7_s > ceil_q) begin
            press = r_ceil;
        end else begin
            press = r7_s[31:16];
        end
    end

    tqcs_pkg::t_result           r_fifo [tqcs_pkg::OUT_DEPTH];
    logic [tqcs_pkg::OUT_AW-1:0] r_wp, r_rp;
    logic [tqcs_pkg::OUT_AW:0]   r_cnt;

    assign o_out.valid     = r_cnt != '0;
    assign o_out.out_taxel = r_fifo[r_rp].taxel;
    assign o_out.pressure  = r_fifo[r_rp].pressure;
    assign pop = o_out.valid && o_out.ready;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_credit <= '0;
            r_cvalid <= '0;
            r_svalid <= '0;
            r1_v <= 1'b0; r2_v <= 1'b0; r3_v <= 1'b0; r4_v <= 1'b0;
            r5_v <= 1'b0; r6_v <= 1'b0; r7_v <= 1'b0;
            r_fwd_hit <= 1'b0;
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (cal_acc) begin
                r_busy <= 1'b1;
            end else if (fit_done) begin
                r_busy <= 1'b0;
            end
            if (fit_done) begin
                r_cvalid[r_cal_addr] <= 1'b1;
            end
            r_credit <= r_credit + tqcs_pkg::CREDIT_W'(smp_acc) - tqcs_pkg::CREDIT_W'(pop);
            r1_v <= smp_acc;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
            r6_v <= r5_v;
            r7_v <= r6_v;
            if (r6_v) begin
                r_svalid[r6_addr] <= 1'b1;
            end
            // write lands on the same edge as the read of the next word
            r_fwd_hit <= r6_v && (r6_addr == r5_addr);
            if (r7_v) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (tqcs_pkg::OUT_AW+1)'(r7_v) - (tqcs_pkg::OUT_AW+1)'(pop);
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (cal_acc) begin
            r_cal_addr <= in_addr;
        end
        r1_t   <= i_in.taxel;
        r1_x   <= i_in.reading;
        r1_xsq <= i_in.reading * i_in.reading;
        r1_cv  <= r_cvalid[in_addr];

        r2_t  <= r1_t;
        r2_ah <= $signed(c1.square[63:32]) * $signed({1'b0, r1_xsq});
        r2_al <= c1.square[31:0] * r1_xsq;
        r2_bh <= $signed(c1.linear[63:32]) * $signed({1'b0, r1_x});
        r2_bl <= c1.linear[31:0] * r1_x;
        r2_c  <= c1.offset;

        r3_t  <= r2_t;
        r3_hi <= 66'(r2_ah) + 66'(r2_bh);
        r3_lo <= $signed({3'b000, r2_al}) + $signed({19'h0, r2_bl}) + 67'(r2_c);

        r4_t   <= r3_t;
        r4_acc <= $signed({r3_hi, 32'h0}) + 100'(r3_lo);

        r5_t     <= r4_t;
        r5_curve <= curve_sat;

        r6_t    <= r5_t;
        r6_pc   <= r5_curve * $signed({1'b0, tqcs_pkg::ALPHA_Q16});
        r6_svld <= r_svalid[r5_addr];
        r_fwd_s <= s_new;

        r7_t <= r6_t;
        r7_s <= s_new;

        if (r7_v) begin
            r_fifo[r_wp].taxel    <= r7_t;
            r_fifo[r_wp].pressure <= press;
        end
    end

endmodule

### tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;

    typedef struct {
        logic                          kind;
        logic [tqcs_pkg::TAXEL_W-1:0]  taxel;
        logic [tqcs_pkg::SAMPLE_W-1:0] rd0;
        logic [tqcs_pkg::SAMPLE_W-1:0] rd1;
        logic [tqcs_pkg::SAMPLE_W-1:0] rd2;
    } t_word;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [tqcs_pkg::CFG_AW-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    tqcs_in_if  in_if();
    tqcs_out_if out_if();

    taxel_quadratic_calibrate_smooth u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // shadow of the block's state
    longint sq_coef [tqcs_pkg::NUM_TAXELS];
    longint lin_coef[tqcs_pkg::NUM_TAXELS];
    longint ofs_coef[tqcs_pkg::NUM_TAXELS];
    longint smooth  [tqcs_pkg::NUM_TAXELS];
    longint ref_lvl [3];
    longint floor_lvl, ceil_lvl;

    t_word             pending_words[$];
    tqcs_pkg::t_result expected_pressure[$];
    t_word             cur_word;
    int      send_idle_pct = 0, recv_stall_pct = 0;
    int      errors = 0, words_sent = 0, results_seen = 0, cals_sent = 0, watchdog = 0;

    function automatic longint q32_divide(logic signed [127:0] num, longint det);
        logic signed [191:0] n, d, q, mx, mn;
        n = 192'(num);
        n = n <<< 32;
        d = 192'(det);
        q = n / d;
        mx = 192'(64'sh7FFF_FFFF_FFFF_FFFF);
        mn = -mx - 1;
        if (q > mx) return 64'sh7FFF_FFFF_FFFF_FFFF;
        if (q < mn) return 64'sh8000_0000_0000_0000;
        return longint'(q[63:0]);
    endfunction

    function automatic logic signed [127:0] lagrange_sum(longint f0, longint f1, longint f2);
        logic signed [127:0] y0, y1, y2, a0, a1, a2;
        y0 = 128'(ref_lvl[0]); y1 = 128'(ref_lvl[1]); y2 = 128'(ref_lvl[2]);
        a0 = 128'(f0); a1 = 128'(f1); a2 = 128'(f2);
        return y0 * a0 - y1 * a1 + y2 * a2;
    endfunction

    task automatic fit_taxel(int t, longint x0, longint x1, longint x2);
        longint det;
        det = (x0 - x1) * (x0 - x2) * (x1 - x2);
        if (det == 0) begin
            sq_coef[t] = 0;
            lin_coef[t] = 64'sh1_0000_0000;
            ofs_coef[t] = 0;
        end else begin
            sq_coef[t]  = q32_divide(lagrange_sum(x1 - x2, x0 - x2, x0 - x1), det);
            lin_coef[t] = q32_divide(-lagrange_sum(x1*x1 - x2*x2, x0*x0 - x2*x2,
                                                   x0*x0 - x1*x1), det);
            ofs_coef[t] = q32_divide(lagrange_sum(x1*x2*(x1 - x2), x0*x2*(x0 - x2),
                                                  x0*x1*(x0 - x1)), det);
        end
    endtask

    function automatic longint curve_at(int t, longint x);
        logic signed [127:0] acc, a, b, c, xs, xx, one;
        a = 128'(sq_coef[t]); b = 128'(lin_coef[t]); c = 128'(ofs_coef[t]);
        xs = 128'(x); xx = 128'(x * x);
        one = 128'sh1_0000_0000;
        acc = (a * xx + b * xs + c) / one;
        if (acc > 128'sd2147483647) return 64'sd2147483647;
        if (acc < -128'sd2147483648) return -64'sd2147483648;
        return longint'(acc[63:0]);
    endfunction

    task automatic condition_word(t_word w);
        longint crv, s;
        tqcs_pkg::t_result r;
        if (w.kind == tqcs_pkg::KIND_CAL) begin
            fit_taxel(int'(w.taxel), longint'(w.rd0), longint'(w.rd1), longint'(w.rd2));
            cals_sent++;
        end else begin
            crv = curve_at(int'(w.taxel), longint'(w.rd0));
            s = (64'sd9830 * (crv * 65536) + 64'sd55706 * smooth[w.taxel]) / 65536;
            smooth[w.taxel] = s;
            r.taxel = w.taxel;
            if (s < floor_lvl * 65536) r.pressure = '0;
            else if (s > ceil_lvl * 65536) r.pressure = ceil_lvl[15:0];
            else r.pressure = s[31:16];
            expected_pressure.push_back(r);
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            in_if.kind <= tqcs_pkg::KIND_SAMPLE;
            in_if.taxel <= '0;
            in_if.reading <= '0;
            in_if.second_reading <= '0;
            in_if.third_reading <= '0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                condition_word(cur_word);
                words_sent++;
            end
            if (!in_if.valid || in_if.ready) begin
                if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    cur_word = pending_words.pop_front();
                    in_if.valid <= 1'b1;
                    in_if.kind <= cur_word.kind;
                    in_if.taxel <= cur_word.taxel;
                    in_if.reading <= cur_word.rd0;
                    in_if.second_reading <= cur_word.rd1;
                    in_if.third_reading <= cur_word.rd2;
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // monitor and watchdog
    always @(posedge i_clk) begin
        tqcs_pkg::t_result e;
        out_if.ready <= i_rst_n && ($urandom_range(99) >= recv_stall_pct);
        if (i_rst_n) begin
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) watchdog = 0;
            else watchdog++;
            if (watchdog >= 20000) begin
                $display("taxel_quadratic_calibrate_smooth verification failed");
                $finish;
            end
        end
        if (i_rst_n && out_if.valid && out_if.ready) begin
            results_seen++;
            if (expected_pressure.size() == 0) begin
                $error("unexpected word: taxel %0d pressure %0d", out_if.out_taxel,
                       out_if.pressure);
                errors++;
            end else begin
                e = expected_pressure.pop_front();
                if (out_if.out_taxel !== e.taxel) begin
                    $error("out_taxel expected %0d actual %0d", e.taxel, out_if.out_taxel);
                    errors++;
                end
                if (out_if.pressure !== e.pressure) begin
                    $error("pressure expected %0d actual %0d", e.pressure, out_if.pressure);
                    errors++;
                end
            end
        end
    end

    task automatic reg_write(tqcs_pkg::t_reg_idx idx, logic [15:0] v);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= tqcs_pkg::CFG_AW'(int'(idx) * 4); pwdata <= {16'd0, v};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            tqcs_pkg::REG_FIRST_REF:   ref_lvl[0] = longint'(v);
            tqcs_pkg::REG_SECOND_REF:  ref_lvl[1] = longint'(v);
            tqcs_pkg::REG_THIRD_REF:   ref_lvl[2] = longint'(v);
            tqcs_pkg::REG_NOISE_FLOOR: floor_lvl = longint'(v);
            default:                   ceil_lvl = longint'(v);
        endcase
    endtask

    task automatic set_levels(logic [15:0] r0, r1, r2, fl, cl);
        reg_write(tqcs_pkg::REG_FIRST_REF, r0);
        reg_write(tqcs_pkg::REG_SECOND_REF, r1);
        reg_write(tqcs_pkg::REG_THIRD_REF, r2);
        reg_write(tqcs_pkg::REG_NOISE_FLOOR, fl);
        reg_write(tqcs_pkg::REG_OUTPUT_CEIL, cl);
    endtask

    task automatic queue_word(logic k, int t, int a, int b, int c);
        t_word w;
        w.kind = k;
        w.taxel = tqcs_pkg::TAXEL_W'(t);
        w.rd0 = tqcs_pkg::SAMPLE_W'(a);
        w.rd1 = tqcs_pkg::SAMPLE_W'(b);
        w.rd2 = tqcs_pkg::SAMPLE_W'(c);
        pending_words.push_back(w);
    endtask

    function automatic int pick_reading();
        case ($urandom_range(5))
            0: return 0;
            1: return 65535;
            2: return int'($urandom_range(255));
            default: return int'($urandom_range(65535));
        endcase
    endfunction

    // drain, then cover a calibration still being fitted
    task automatic wait_idle();
        wait (pending_words.size() == 0 && !in_if.valid && expected_pressure.size() == 0);
        repeat (400) @(posedge i_clk);
    endtask

    initial begin
        int hot;
        for (int t = 0; t < tqcs_pkg::NUM_TAXELS; t++) begin
            sq_coef[t] = 0; lin_coef[t] = 64'sh1_0000_0000; ofs_coef[t] = 0; smooth[t] = 0;
        end
        ref_lvl[0] = 0; ref_lvl[1] = 0; ref_lvl[2] = 0;
        floor_lvl = 0; ceil_lvl = 65535;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: identity curve at reset, extremes, calibrations
        set_levels(16'd0, 16'd32768, 16'd65535, 16'd0, 16'd65535);
        queue_word(tqcs_pkg::KIND_SAMPLE, 0, 0, 0, 0);
        queue_word(tqcs_pkg::KIND_SAMPLE, 127, 65535, 65535, 65535);
        queue_word(tqcs_pkg::KIND_SAMPLE, 127, 65535, 0, 0);
        queue_word(tqcs_pkg::KIND_CAL, 5, 1000, 1000, 3000);      // coinciding readings
        queue_word(tqcs_pkg::KIND_SAMPLE, 5, 2000, 0, 0);
        queue_word(tqcs_pkg::KIND_CAL, 6, 0, 32768, 65535);
        queue_word(tqcs_pkg::KIND_SAMPLE, 6, 65535, 0, 0);
        queue_word(tqcs_pkg::KIND_SAMPLE, 6, 16384, 0, 0);
        queue_word(tqcs_pkg::KIND_CAL, 7, 0, 1, 2);               // huge coefficients
        queue_word(tqcs_pkg::KIND_SAMPLE, 7, 65535, 0, 0);
        queue_word(tqcs_pkg::KIND_SAMPLE, 7, 1, 0, 0);
        queue_word(tqcs_pkg::KIND_CAL, 8, 65535, 65534, 0);
        queue_word(tqcs_pkg::KIND_SAMPLE, 8, 0, 0, 0);
        queue_word(tqcs_pkg::KIND_SAMPLE, 8, 30000, 0, 0);
        queue_word(tqcs_pkg::KIND_CAL, 127, 65535, 65535, 65535);
        queue_word(tqcs_pkg::KIND_SAMPLE, 127, 12345, 0, 0);
        wait_idle();
        set_levels(16'd65535, 16'd0, 16'd65535, 16'd65535, 16'd0); // ceiling below floor
        queue_word(tqcs_pkg::KIND_SAMPLE, 6, 100, 0, 0);
        queue_word(tqcs_pkg::KIND_SAMPLE, 0, 65535, 0, 0);
        queue_word(tqcs_pkg::KIND_CAL, 9, 100, 200, 300);
        queue_word(tqcs_pkg::KIND_SAMPLE, 9, 200, 0, 0);
        queue_word(tqcs_pkg::KIND_SAMPLE, 9, 65535, 0, 0);
        wait_idle();

        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
                default: begin send_idle_pct = 7; recv_stall_pct = 7; end
            endcase
            case (ph)
                0: set_levels(16'd0, 16'd20000, 16'd60000, 16'd0, 16'd65535);
                3: set_levels(16'd65535, 16'd65535, 16'd65535, 16'd0, 16'd65535);
                5: set_levels(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
                default: set_levels(16'($urandom_range(65535)), 16'($urandom_range(65535)),
                                    16'($urandom_range(65535)), 16'($urandom_range(3000)),
                                    16'($urandom_range(65535)));
            endcase
            hot = int'($urandom_range(tqcs_pkg::NUM_TAXELS - 1));
            for (int n = 0; n < 200; n++) begin
                int t, a;
                // two hot taxels give back-to-back hits on the same entry
                t = ($urandom_range(3) == 0)
                    ? int'((hot + $urandom_range(1)) % tqcs_pkg::NUM_TAXELS)
                    : int'($urandom_range(tqcs_pkg::NUM_TAXELS - 1));
                a = pick_reading();
                if ($urandom_range(99) < 4)
                    queue_word(tqcs_pkg::KIND_CAL, t, a,
                               ($urandom_range(7) == 0) ? a : pick_reading(), pick_reading());
                else
                    queue_word(tqcs_pkg::KIND_SAMPLE, t, a, int'($urandom_range(65535)),
                               int'($urandom_range(65535)));
            end
            wait_idle();
        end

        $display("covered %0d words (%0d calibrations), %0d pressure words checked",
                 words_sent, cals_sent, results_seen);
        $display("across 8 register settings and four handshake pacing modes");
        if (errors == 0) begin
            $display("taxel_quadratic_calibrate_smooth verification clean");
        end else begin
            $display("taxel_quadratic_calibrate_smooth verification failed");
        end
        $finish;
    end
endmodule
